[rtl/nonpreemptive_priority_scheduler_core_assert.svh]
// ----------------------------------------------------------------------------
// scheduler core assertion macros
// implication checks on the core clock, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_CORE_ASSERT_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define NPS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/npsch_pkg.sv]
// ----------------------------------------------------------------------------
// npsch_pkg
// shared widths, the job entry carried along the cell ring and the scan result
// ----------------------------------------------------------------------------
`default_nettype none

package npsch_pkg;

	localparam int MAX_PROCS_DEF = 16;
	localparam int TIME_W        = 16;
	localparam int PRIO_W        = 8;
	localparam int TICK_W        = 21;
	localparam int SUM_W         = 25;
	localparam int JIDX_W        = 4;

	// payload of one ring cell, the valid bit travels beside it
	typedef struct packed {
		logic              done;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [PRIO_W-1:0] prio;
		logic [TICK_W-1:0] finish;
	} job_t;

	// outcome of one scan pass, including the entry at the head this cycle
	typedef struct packed {
		logic              found;
		logic              any;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] earliest;
	} scan_t;

endpackage

`default_nettype wire

[rtl/npsch_cell.sv]
// ----------------------------------------------------------------------------
// npsch_cell
// one ring cell: holds one job and takes its neighbor's job on every shift
// ----------------------------------------------------------------------------
`default_nettype none

module npsch_cell import npsch_pkg::*; #(
	parameter int IW = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              shift,
	input  wire logic              clear,
	input  wire logic              mark,
	input  wire logic [TICK_W-1:0] tick,
	input  wire logic              d_valid,
	input  wire job_t              d,
	input  wire logic [IW-1:0]     d_idx,
	output logic                   q_valid,
	output job_t                   q,
	output logic [IW-1:0]          q_idx
);

	logic          valid_q;
	job_t          job_q;
	logic [IW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d_valid;
		end
	end

	// a mark retires the job at the current tick as it passes
	always_ff @(posedge clk) begin
		if (shift) begin
			job_q.done    <= d.done | mark;
			job_q.arrival <= d.arrival;
			job_q.burst   <= d.burst;
			job_q.prio    <= d.prio;
			job_q.finish  <= mark ? tick : d.finish;
			idx_q         <= d_idx;
		end
	end

	assign q_valid = valid_q;
	assign q       = job_q;
	assign q_idx   = idx_q;

endmodule

`default_nettype wire

[rtl/npsch_scan.sv]
// ----------------------------------------------------------------------------
// npsch_scan
// head evaluator: tracks the best arrived job and the earliest pending arrival
// ----------------------------------------------------------------------------
`default_nettype none

module npsch_scan import npsch_pkg::*; #(
	parameter int IW = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              start,
	input  wire logic              head_valid,
	input  wire job_t              head,
	input  wire logic [IW-1:0]     head_idx,
	input  wire logic              head_mark,
	input  wire logic [TICK_W-1:0] tick,
	output scan_t                  res,
	output logic [IW-1:0]          res_idx
);

	logic              found_q;
	logic              any_q;
	logic [PRIO_W-1:0] prio_q;
	logic [TIME_W-1:0] burst_q;
	logic [TIME_W-1:0] earliest_q;
	logic [IW-1:0]     idx_q;

	logic              b_found;
	logic              b_any;
	logic [PRIO_W-1:0] b_prio;
	logic [TIME_W-1:0] b_burst;
	logic [TIME_W-1:0] b_earliest;
	logic [IW-1:0]     b_idx;
	logic              pending;
	logic              eligible;
	logic              take;
	logic              sooner;
	logic [PRIO_W-1:0] n_prio;

	always_comb begin
		b_found    = start ? 1'b0 : found_q;
		b_any      = start ? 1'b0 : any_q;
		b_prio     = prio_q;
		b_burst    = burst_q;
		b_earliest = earliest_q;
		b_idx      = idx_q;

		pending  = head_valid & ~(head.done | head_mark);
		eligible = pending & ({{(TICK_W-TIME_W){1'b0}}, head.arrival} <= tick);
		// strict compare keeps the lower index on a tie
		take     = eligible & (~b_found | (head.prio < b_prio));
		sooner   = pending & (~b_any | (head.arrival < b_earliest));

		res.found    = b_found | take;
		res.any      = b_any | pending;
		res.burst    = take ? head.burst : b_burst;
		res.earliest = sooner ? head.arrival : b_earliest;
		res_idx      = take ? head_idx : b_idx;
		n_prio       = take ? head.prio : b_prio;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			any_q   <= 1'b0;
		end else if (step) begin
			found_q <= res.found;
			any_q   <= res.any;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			prio_q     <= n_prio;
			burst_q    <= res.burst;
			earliest_q <= res.earliest;
			idx_q      <= res_idx;
		end
	end

endmodule

`default_nettype wire

[rtl/nonpreemptive_priority_scheduler_core.sv]
// Non-preemptive priority scheduler. Jobs stream in one per cycle, each held
// in its own cell of a ring of MAX_PROCS cells; the transfer with tlast set
// closes the set and starts scheduling, and no job is taken while the set is
// being scheduled or its results are being read out of the ring. The last
// result of a set may still be waiting at the output when the next set starts
// loading. Each scheduling decision is one full rotation of the ring, with
// the head cell evaluated once a cycle; a decision either retires the
// lowest-priority arrived job (lowest index on a tie) or, when nothing has
// arrived, jumps the tick to the earliest pending arrival. A set of n jobs
// therefore takes between n and 2n decision passes plus one output pass in
// which the results leave in input order, one per cycle unless the output
// side stalls. Jobs beyond MAX_PROCS in a set are dropped.
`default_nettype none
`include "nonpreemptive_priority_scheduler_core_assert.svh"

// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_core
// cell ring, head scan unit, schedule sequencer and result register
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_core import npsch_pkg::*; #(
	parameter int MAX_PROCS = MAX_PROCS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// arrival_time[15:0], burst_time[31:16], job_priority[39:32]
	input  wire logic [39:0]  s_tdata,
	// last_job
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// job_index[3:0], completion_time[24:4], turnaround_time[45:25],
	// waiting_time[66:46], response_time[87:67], total_turnaround[112:88],
	// total_waiting[137:113], zero fill[143:138]
	output logic [143:0]      m_tdata,
	// last_result
	output logic              m_tlast
);

	localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNW = $clog2(MAX_PROCS + 1);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]        state_q;
	logic [CNW-1:0]    count_q;
	logic [CNW-1:0]    left_q;
	logic [IW-1:0]     cnt_q;
	logic [TICK_W-1:0] tick_q;
	logic              mark_v_q;
	logic [IW-1:0]     mark_idx_q;
	logic [SUM_W-1:0]  sum_tat_q;
	logic [SUM_W-1:0]  sum_wt_q;

	logic              out_v_q;
	logic [JIDX_W-1:0] o_idx_q;
	logic [TICK_W-1:0] o_ct_q;
	logic [TICK_W-1:0] o_tat_q;
	logic [TICK_W-1:0] o_wt_q;
	logic [SUM_W-1:0]  o_sum_tat_q;
	logic [SUM_W-1:0]  o_sum_wt_q;
	logic              o_last_q;

	logic              cell_v   [MAX_PROCS];
	job_t              cell_j   [MAX_PROCS];
	logic [IW-1:0]     cell_idx [MAX_PROCS];

	logic              in_xfer;
	logic              store;
	logic [CNW-1:0]    count_inc;
	logic              pass_end_cnt;
	logic              out_step;
	logic              rot;
	logic              shift;
	logic              out_done;
	logic              mark_hit;
	logic              scan_step;
	logic              scan_end;
	job_t              new_job;
	job_t              tail_d;
	logic              tail_v;
	logic [IW-1:0]     tail_idx;
	scan_t             sc;
	logic [IW-1:0]     sc_idx;

	logic [TICK_W-1:0] ct;
	logic [TICK_W-1:0] tat;
	logic [TICK_W-1:0] wt;
	logic [SUM_W-1:0]  n_sum_tat;
	logic [SUM_W-1:0]  n_sum_wt;
	logic [CNW-1:0]    count_m1;
	logic [CNW-1:0]    head_idx_ext;
	logic [IW+JIDX_W-1:0] head_idx_wide;

	assign s_tready     = (state_q == ST_LOAD);
	assign in_xfer      = s_tvalid & s_tready;
	assign store        = in_xfer & (count_q < CNW'(MAX_PROCS));
	assign count_inc    = count_q + CNW'(store);
	assign pass_end_cnt = (cnt_q == IW'(MAX_PROCS - 1));

	assign mark_hit  = (state_q != ST_LOAD) & mark_v_q & cell_v[0]
		& (cell_idx[0] == mark_idx_q);
	assign out_step  = (state_q == ST_OUT) & (~cell_v[0] | ~out_v_q | m_tready);
	assign scan_step = (state_q == ST_SCAN);
	assign rot       = scan_step | out_step;
	assign shift     = store | rot;
	assign scan_end  = scan_step & pass_end_cnt;
	assign out_done  = out_step & pass_end_cnt;

	always_comb begin
		new_job.done    = 1'b0;
		new_job.arrival = s_tdata[15:0];
		new_job.burst   = s_tdata[31:16];
		new_job.prio    = s_tdata[39:32];
		new_job.finish  = '0;
	end

	// new jobs enter at the tail; otherwise the head wraps round to the tail
	assign tail_d   = (state_q == ST_LOAD) ? new_job : cell_j[0];
	assign tail_v   = (state_q == ST_LOAD) ? 1'b1 : cell_v[0];
	assign tail_idx = (state_q == ST_LOAD) ? count_q[IW-1:0] : cell_idx[0];

	for (genvar k = 0; k < MAX_PROCS; k++) begin : g_ring
		if (k == MAX_PROCS - 1) begin : g_tail
			npsch_cell #(.IW(IW)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (shift),
				.clear   (out_done),
				.mark    (mark_hit & rot),
				.tick    (tick_q),
				.d_valid (tail_v),
				.d       (tail_d),
				.d_idx   (tail_idx),
				.q_valid (cell_v[k]),
				.q       (cell_j[k]),
				.q_idx   (cell_idx[k])
			);
		end else begin : g_mid
			npsch_cell #(.IW(IW)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (shift),
				.clear   (out_done),
				.mark    (1'b0),
				.tick    (tick_q),
				.d_valid (cell_v[k+1]),
				.d       (cell_j[k+1]),
				.d_idx   (cell_idx[k+1]),
				.q_valid (cell_v[k]),
				.q       (cell_j[k]),
				.q_idx   (cell_idx[k])
			);
		end
	end

	npsch_scan #(.IW(IW)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (scan_step),
		.start      (cnt_q == '0),
		.head_valid (cell_v[0]),
		.head       (cell_j[0]),
		.head_idx   (cell_idx[0]),
		.head_mark  (mark_hit),
		.tick       (tick_q),
		.res        (sc),
		.res_idx    (sc_idx)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			left_q     <= '0;
			cnt_q      <= '0;
			tick_q     <= '0;
			mark_v_q   <= 1'b0;
			mark_idx_q <= '0;
			sum_tat_q  <= '0;
			sum_wt_q   <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						count_q <= count_inc;
						if (s_tlast) begin
							state_q  <= ST_SCAN;
							left_q   <= count_inc;
							cnt_q    <= '0;
							mark_v_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					cnt_q <= pass_end_cnt ? '0 : cnt_q + IW'(1);
					if (scan_end) begin
						if (sc.found) begin
							tick_q     <= tick_q + {{(TICK_W-TIME_W){1'b0}}, sc.burst};
							mark_v_q   <= 1'b1;
							mark_idx_q <= sc_idx;
							left_q     <= left_q - CNW'(1);
							if (left_q == CNW'(1)) begin
								state_q <= ST_OUT;
							end
						end else begin
							// nothing arrived yet: idle up to the next arrival
							tick_q   <= {{(TICK_W-TIME_W){1'b0}}, sc.earliest};
							mark_v_q <= 1'b0;
						end
					end
				end
				ST_OUT: begin
					if (out_step) begin
						cnt_q <= pass_end_cnt ? '0 : cnt_q + IW'(1);
						if (cell_v[0]) begin
							sum_tat_q <= n_sum_tat;
							sum_wt_q  <= n_sum_wt;
						end
						if (pass_end_cnt) begin
							state_q   <= ST_LOAD;
							count_q   <= '0;
							tick_q    <= '0;
							mark_v_q  <= 1'b0;
							sum_tat_q <= '0;
							sum_wt_q  <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// result for the job at the head
	always_comb begin
		ct            = mark_hit ? tick_q : cell_j[0].finish;
		tat           = ct - {{(TICK_W-TIME_W){1'b0}}, cell_j[0].arrival};
		wt            = tat - {{(TICK_W-TIME_W){1'b0}}, cell_j[0].burst};
		n_sum_tat     = sum_tat_q + {{(SUM_W-TICK_W){1'b0}}, tat};
		n_sum_wt      = sum_wt_q + {{(SUM_W-TICK_W){1'b0}}, wt};
		count_m1      = count_q - CNW'(1);
		head_idx_ext  = CNW'(cell_idx[0]);
		head_idx_wide = {{JIDX_W{1'b0}}, cell_idx[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_step & cell_v[0]) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_step & cell_v[0]) begin
			o_idx_q     <= head_idx_wide[JIDX_W-1:0];
			o_ct_q      <= ct;
			o_tat_q     <= tat;
			o_wt_q      <= wt;
			o_sum_tat_q <= n_sum_tat;
			o_sum_wt_q  <= n_sum_wt;
			o_last_q    <= (head_idx_ext == count_m1);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {6'd0, o_sum_wt_q, o_sum_tat_q, o_wt_q, o_wt_q, o_tat_q, o_ct_q,
		o_idx_q};

	`NPS_ASSERT_IMPLY(a_left_nonzero, state_q == ST_SCAN, left_q != '0, "scan with no job left")
	`NPS_ASSERT_IMPLY(a_count_bound, 1'b1, count_q <= CNW'(MAX_PROCS), "job count over depth")
	`NPS_ASSERT_IMPLY(a_mark_idle, state_q == ST_LOAD, !mark_v_q, "retire mark live while loading")
	`NPS_ASSERT_NEXT(a_out_source, !m_tvalid && (state_q != ST_OUT), !m_tvalid,
		"result outside output pass")

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives job sets into the priority scheduler core over the input stream and
// checks every per-job result against a local schedule predictor, under
// several sender and receiver idling mixes and one long output hold-off
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import npsch_pkg::*; ();

	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 8000;
	localparam int SETTLE_CYCLES  = 200;
	localparam int PHASE_ITEMS    = 82;
	localparam int REPORT_LIMIT   = 10;

	typedef struct {
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [PRIO_W-1:0] prio;
		logic              last;
	} job_item_t;

	// same layout as m_tdata, lowest field last
	typedef struct packed {
		logic [5:0]        fill;
		logic [SUM_W-1:0]  total_waiting;
		logic [SUM_W-1:0]  total_turnaround;
		logic [TICK_W-1:0] response;
		logic [TICK_W-1:0] waiting;
		logic [TICK_W-1:0] turnaround;
		logic [TICK_W-1:0] completion;
		logic [JIDX_W-1:0] job_index;
	} job_result_t;

	typedef struct {
		job_result_t word;
		logic        last;
	} expected_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic m_tlast;

	nonpreemptive_priority_scheduler_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// pending jobs and expected results
	job_item_t        job_items_q[$];
	expected_result_t job_results_q[$];

	// predictor state
	logic [TIME_W-1:0] pred_arrival [MAX_PROCS_DEF];
	logic [TIME_W-1:0] pred_burst   [MAX_PROCS_DEF];
	logic [PRIO_W-1:0] pred_prio    [MAX_PROCS_DEF];
	logic [TICK_W-1:0] pred_finish  [MAX_PROCS_DEF];
	logic              pred_done    [MAX_PROCS_DEF];
	int                pred_count = 0;
	logic [TICK_W-1:0] pred_tick = '0;

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int hold_left = 0;

	int mismatch_count = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	// runs the whole set to completion, lowest priority value first among
	// arrived jobs, lowest index on a tie, tick jumps forward when none arrived
	task automatic schedule_job_set();
		int remaining;
		int pick;
		int i;
		logic [PRIO_W-1:0] best;
		logic [TIME_W-1:0] earliest;
		logic any_pending;
		logic [TICK_W-1:0] tat;
		logic [TICK_W-1:0] wt;
		logic [SUM_W-1:0] sum_tat;
		logic [SUM_W-1:0] sum_wt;
		expected_result_t res;

		remaining = pred_count;
		best = '0;
		earliest = '0;
		while (remaining > 0) begin
			pick = -1;
			any_pending = 1'b0;
			for (i = 0; i < pred_count; i++) begin
				if (!pred_done[i]) begin
					if (!any_pending || pred_arrival[i] < earliest)
						earliest = pred_arrival[i];
					any_pending = 1'b1;
					if (TICK_W'(pred_arrival[i]) <= pred_tick) begin
						if (pick < 0 || pred_prio[i] < best) begin
							best = pred_prio[i];
							pick = i;
						end
					end
				end
			end
			if (pick < 0) begin
				pred_tick = TICK_W'(earliest);
			end else begin
				pred_tick = pred_tick + TICK_W'(pred_burst[pick]);
				pred_finish[pick] = pred_tick;
				pred_done[pick] = 1'b1;
				remaining--;
			end
		end

		sum_tat = '0;
		sum_wt = '0;
		for (i = 0; i < pred_count; i++) begin
			tat = pred_finish[i] - TICK_W'(pred_arrival[i]);
			wt = tat - TICK_W'(pred_burst[i]);
			sum_tat = sum_tat + SUM_W'(tat);
			sum_wt = sum_wt + SUM_W'(wt);
			res.word = '0;
			res.word.job_index = JIDX_W'(i);
			res.word.completion = pred_finish[i];
			res.word.turnaround = tat;
			res.word.waiting = wt;
			res.word.response = wt;
			res.word.total_turnaround = sum_tat;
			res.word.total_waiting = sum_wt;
			res.last = (i + 1 == pred_count);
			job_results_q.push_back(res);
		end

		for (i = 0; i < MAX_PROCS_DEF; i++)
			pred_done[i] = 1'b0;
		pred_count = 0;
		pred_tick = '0;
	endtask

	task automatic accept_job(input job_item_t it);
		if (pred_count < MAX_PROCS_DEF) begin
			pred_arrival[pred_count] = it.arrival;
			pred_burst[pred_count] = it.burst;
			pred_prio[pred_count] = it.prio;
			pred_done[pred_count] = 1'b0;
			pred_count++;
		end
		if (it.last)
			schedule_job_set();
	endtask

	task automatic compare_field(input string name, input logic [SUM_W-1:0] exp_v,
			input logic [SUM_W-1:0] act_v);
		if (exp_v !== act_v) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("mismatch %s: expected %0d, got %0d", name, exp_v, act_v);
		end
	endtask

	task automatic check_result(input job_result_t act, input logic act_last);
		expected_result_t exp_r;
		if (job_results_q.size() == 0) begin
			error_count++;
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("unexpected result for job %0d", act.job_index);
		end else begin
			exp_r = job_results_q.pop_front();
			compare_field("job_index", exp_r.word.job_index, act.job_index);
			compare_field("completion_time", exp_r.word.completion, act.completion);
			compare_field("turnaround_time", exp_r.word.turnaround, act.turnaround);
			compare_field("waiting_time", exp_r.word.waiting, act.waiting);
			compare_field("response_time", exp_r.word.response, act.response);
			compare_field("total_turnaround", exp_r.word.total_turnaround,
				act.total_turnaround);
			compare_field("total_waiting", exp_r.word.total_waiting, act.total_waiting);
			compare_field("last_result", exp_r.last, act_last);
		end
	endtask

	// input side: hold the offered job until it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				accept_job(job_items_q[0]);
				void'(job_items_q.pop_front());
			end
			if (!(s_tvalid && !s_tready)) begin
				if (job_items_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= {job_items_q[0].prio, job_items_q[0].burst,
						job_items_q[0].arrival};
					s_tlast <= job_items_q[0].last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req && !hold_taken && m_tvalid) begin
			hold_left <= HOLD_CYCLES;
			hold_taken <= 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result(job_result_t'(m_tdata), m_tlast);
	end

	// counts cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic void add_job(input int arrival, input int burst, input int prio,
			input logic last);
		job_item_t it;
		it.arrival = TIME_W'(arrival);
		it.burst = TIME_W'(burst);
		it.prio = PRIO_W'(prio);
		it.last = last;
		job_items_q.push_back(it);
	endfunction

	// one set of random size and shape; returns the number of jobs pushed
	function automatic int add_random_set();
		int n;
		int r;
		int shape;
		int prio_max;
		int i;
		int arrival;
		int burst;

		r = $urandom_range(99);
		if (r < 75)
			n = $urandom_range(6, 1);
		else if (r < 93)
			n = $urandom_range(16, 7);
		else
			n = $urandom_range(19, 17);
		shape = $urandom_range(2);
		prio_max = $urandom_range(1) ? 3 : 255;
		for (i = 0; i < n; i++) begin
			case (shape)
				0: begin
					// heavy contention, short jobs
					arrival = $urandom_range(40);
					burst = $urandom_range(30);
				end
				1: begin
					arrival = $urandom_range(65535);
					burst = $urandom_range(65535);
				end
				default: begin
					// spread arrivals, leaves the core idle between jobs
					arrival = i * $urandom_range(200) + $urandom_range(50);
					burst = $urandom_range(60);
				end
			endcase
			add_job(arrival, burst, $urandom_range(prio_max), i == n - 1);
		end
		return n;
	endfunction

	task automatic wait_drained();
		while (job_items_q.size() != 0 || job_results_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall_pct,
			input logic with_hold);
		int pushed;
		@(negedge clk);
		sender_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		hold_req = with_hold;
		pushed = 0;
		while (pushed < PHASE_ITEMS)
			pushed += add_random_set();
		wait_drained();
	endtask

	initial begin
		int i;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero burst at tick zero, a lone late job, ties and gaps
		add_job(0, 0, 0, 1'b1);
		add_job(65535, 65535, 255, 1'b1);
		add_job(2, 3, 7, 1'b0);
		add_job(0, 4, 7, 1'b0);
		add_job(2, 10, 7, 1'b0);
		add_job(100, 1, 0, 1'b1);
		// full store of longest jobs, then one dropped job and a dropped closer
		for (i = 0; i < MAX_PROCS_DEF; i++)
			add_job(0, 65535, (i % 2 == 0) ? 255 - i : i, 1'b0);
		add_job(65535, 0, 0, 1'b0);
		add_job(0, 65535, 255, 1'b1);
		wait_drained();

		run_random_phase(0, 0, 1'b1);
		run_random_phase(75, 0, 1'b0);
		run_random_phase(0, 75, 1'b0);
		run_random_phase(29, 29, 1'b0);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && error_count == 0 && job_results_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
